[rtl/shannon_entropy_accumulator_top_defines.svh]
// ---------------------------------------------------------------------------
// assertion macros for the shannon entropy accumulator
// they expect clk and rst to be visible at the place of use
// ---------------------------------------------------------------------------
`ifndef SHANNON_ENTROPY_ACCUMULATOR_TOP_DEFINES_SVH
`define SHANNON_ENTROPY_ACCUMULATOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SEA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sea check failed");

// antecedent implies consequent in the next cycle
`define SEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sea check failed");

`endif

[rtl/sea_pkg.sv]
// ---------------------------------------------------------------------------
// sea_pkg
// types and constants shared by the entropy accumulator modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sea_pkg;

  localparam int PROB_FRAC_BITS = 16;
  localparam int PROB_W         = PROB_FRAC_BITS + 1;
  localparam int LOG_FRAC_BITS  = 16;
  localparam int MANT_FRAC      = 30;
  localparam int MANT_W         = MANT_FRAC + 1;
  localparam int SHIFT_W        = $clog2(PROB_FRAC_BITS + 1);
  localparam int NEGL_W         = SHIFT_W + LOG_FRAC_BITS;
  localparam int PROD_W         = PROB_W + NEGL_W;
  localparam int TERM_W         = PROD_W + 1 - PROB_FRAC_BITS;
  localparam int ENTROPY_W      = 32;

  localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_REFRESH = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;

  localparam logic [1:0] KIND_REFRESH = 2'd0;
  localparam logic [1:0] KIND_NOPROB  = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              has_probability;
    logic [PROB_W-1:0] probability;
  } req_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [ENTROPY_W-1:0] entropy_bits;
  } res_t;

endpackage

[rtl/sea_log2.sv]
// ---------------------------------------------------------------------------
// sea_log2
// serial -log2(p): bit-per-cycle normalize, then one squaring per fraction bit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sea_log2 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sea_pkg::PROB_W-1:0]  p,
  output logic                        done,
  output logic [sea_pkg::NEGL_W-1:0]  negl
);
  import sea_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_ITER = 2'd2;
  localparam int ITER_W = $clog2(LOG_FRAC_BITS);

  logic [1:0]               state;
  logic [MANT_W-1:0]        x;
  logic [SHIFT_W-1:0]       cnt;
  logic [ITER_W-1:0]        iter;
  logic [LOG_FRAC_BITS-1:0] f;
  logic [2*MANT_W-1:0]      sq;
  logic [MANT_W:0]          sq_sh;

  assign sq    = {{MANT_W{1'b0}}, x} * {{MANT_W{1'b0}}, x};
  assign sq_sh = sq[MANT_FRAC +: MANT_W + 1];

  // integer part counts the normalizing shifts, fraction comes from squaring
  assign negl = {cnt, {LOG_FRAC_BITS{1'b0}}} - NEGL_W'(f);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (x[MANT_FRAC]) begin
            state <= L_ITER;
          end
        end
        L_ITER: begin
          if (iter == ITER_W'(LOG_FRAC_BITS - 1)) begin
            state <= L_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        x    <= MANT_W'(p) << (MANT_FRAC - PROB_FRAC_BITS);
        cnt  <= '0;
        iter <= '0;
        f    <= '0;
      end
      L_NORM: begin
        if (!x[MANT_FRAC]) begin
          x   <= x << 1;
          cnt <= cnt + SHIFT_W'(1);
        end
      end
      L_ITER: begin
        iter <= iter + ITER_W'(1);
        if (sq_sh[MANT_W]) begin
          x <= sq_sh[MANT_W:1];
          f <= {f[LOG_FRAC_BITS-2:0], 1'b1};
        end else begin
          x <= sq_sh[MANT_W-1:0];
          f <= {f[LOG_FRAC_BITS-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/sea_mul.sv]
// ---------------------------------------------------------------------------
// sea_mul
// shift-add multiplier, one bit of the probability per cycle, msb first
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sea_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sea_pkg::PROB_W-1:0]  a,
  input  logic [sea_pkg::NEGL_W-1:0]  b,
  output logic                        done,
  output logic [sea_pkg::PROD_W-1:0]  prod
);
  import sea_pkg::*;

  localparam int CNT_W = $clog2(PROB_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [PROB_W-1:0] ash;
  logic [NEGL_W-1:0] bop;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(PROB_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ash  <= a;
      bop  <= b;
      prod <= '0;
      cnt  <= '0;
    end else if (busy) begin
      ash  <= ash << 1;
      cnt  <= cnt + CNT_W'(1);
      prod <= (prod << 1) + (ash[PROB_W-1] ? PROD_W'(bop) : '0);
    end
  end

endmodule

[rtl/shannon_entropy_accumulator_top.sv]
// ---------------------------------------------------------------------------
// shannon_entropy_accumulator_top
// running shannon entropy, in bits, over a stream of probability samples
// ---------------------------------------------------------------------------
// req channel (req_valid/req_ready/req_data) takes samples, refresh marks and
// end marks; res channel (res_valid/res_ready/res_data) returns entropy
// results. a sample with a probability adds -p*log2(p) to a saturating sum
// and gives no result; a sample without one returns a pass-through beat.
// a refresh returns the sum, saves it and clears it; an end mark returns the
// sum, or the saved sum, or nothing if both are zero.
// marks and pass-through samples show their result beat, if any, the cycle
// after acceptance. a sample with a nonzero probability keeps the input closed
// from its accepting edge until the state returns to idle: one normalize
// shift per leading zero, 16 squarings in the log2 unit (one 31x31 square
// per cycle), a handoff, 17 bit-serial multiply steps, a handoff, and the
// accumulate.
// reset clears both sums and drops any pending result. while a result beat
// is stalled by res_ready, samples with a probability are still accepted;
// beats that would return a result wait until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shannon_entropy_accumulator_top_defines.svh"

module shannon_entropy_accumulator_top #(
  parameter int SUM_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sea_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output sea_pkg::res_t res_data
);
  import sea_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOG  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam int EXT_W = (SUM_WIDTH > ENTROPY_W) ? SUM_WIDTH : ENTROPY_W;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (PROB_FRAC_BITS - 1);

  logic [2:0]           state;
  logic [SUM_WIDTH-1:0] sum;
  logic [SUM_WIDTH-1:0] prev;
  logic [PROB_W-1:0]    p_reg;
  logic [TERM_W-1:0]    term;
  logic [PROB_W-1:0]    p_clamp;
  logic [SUM_WIDTH-1:0] end_val;
  logic [SUM_WIDTH:0]   acc_sum;
  logic [PROD_W:0]      rnd;
  logic                 prob_sample;
  logic                 req_fire;
  logic                 res_set;
  logic                 log_start;
  logic                 log_done;
  logic [NEGL_W-1:0]    negl;
  logic                 mul_done;
  logic [PROD_W-1:0]    prod;

  function automatic logic [ENTROPY_W-1:0] sat_out(input logic [SUM_WIDTH-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > EXT_W'({ENTROPY_W{1'b1}})) begin
      return '1;
    end
    return ext[ENTROPY_W-1:0];
  endfunction

  assign prob_sample = (req_data.req_type != REQ_REFRESH) &&
                       (req_data.req_type != REQ_END) && req_data.has_probability;
  assign req_ready   = (state == S_IDLE) && (!res_valid || res_ready || prob_sample);
  assign req_fire    = req_valid && req_ready;
  // every accepted beat but a probability sample or an empty end mark returns one
  assign res_set     = req_fire && !prob_sample &&
                       ((req_data.req_type != REQ_END) || (end_val != '0));
  assign p_clamp     = (req_data.probability > PROB_ONE) ? PROB_ONE : req_data.probability;
  assign end_val     = (sum != '0) ? sum : prev;
  assign log_start   = req_fire && prob_sample && (p_clamp != '0);
  assign acc_sum     = {1'b0, sum} + (SUM_WIDTH + 1)'(term);
  assign rnd         = {1'b0, prod} + ROUND_HALF;

  sea_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .p     (p_clamp),
    .done  (log_done),
    .negl  (negl)
  );

  sea_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (log_done),
    .a     (p_reg),
    .b     (negl),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum       <= '0;
      prev      <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_set || (res_valid && !res_ready);
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req_data.req_type == REQ_REFRESH) begin
              prev <= sum;
              sum  <= '0;
            end else if (req_data.req_type == REQ_END) begin
              prev <= '0;
            end else if (req_data.has_probability && p_clamp != '0) begin
              state <= S_LOG;
            end
          end
        end
        S_LOG: begin
          if (log_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          // saturate on carry out of the sum
          sum   <= acc_sum[SUM_WIDTH] ? '1 : acc_sum[SUM_WIDTH-1:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (log_start) begin
      p_reg <= p_clamp;
    end
    if (mul_done) begin
      term <= rnd[PROD_W:PROB_FRAC_BITS];
    end
    if (state == S_IDLE && req_fire) begin
      if (req_data.req_type == REQ_REFRESH) begin
        res_data.result_kind  <= KIND_REFRESH;
        res_data.entropy_bits <= sat_out(sum);
      end else if (req_data.req_type == REQ_END) begin
        if (end_val != '0) begin
          res_data.result_kind  <= KIND_FINAL;
          res_data.entropy_bits <= sat_out(end_val);
        end
      end else if (!req_data.has_probability) begin
        res_data.result_kind  <= KIND_NOPROB;
        res_data.entropy_bits <= '0;
      end
    end
  end

  `SEA_ASSERT_NEXT(a_start_enters_log, log_start, state == S_LOG)
  `SEA_ASSERT_SAME(a_log_done_in_log, log_done, state == S_LOG)
  `SEA_ASSERT_SAME(a_mul_done_in_mul, mul_done, state == S_MUL)
  `SEA_ASSERT_NEXT(a_refresh_clears,
    req_fire && req_data.req_type == REQ_REFRESH,
    sum == '0 && res_valid && res_data.result_kind == KIND_REFRESH)

endmodule
